@@ src/pftbp_pkg.sv @@
// Shared types and constants of the per-flow token bucket policer.
package pftbp_pkg;

  localparam int unsigned IdxW   = 12;
  localparam int unsigned LenW   = 16;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned RateW  = 37;
  localparam int unsigned BurstW = 32;
  localparam int unsigned CfgIdxW = 2;

  // Clamped elapsed time, full product and refill limit widths.
  localparam int unsigned DeltaW = 62;
  localparam int unsigned ProdW  = 99;
  localparam int unsigned LimW   = 62;
  localparam int unsigned RemW   = 30;

  localparam int unsigned StepW    = 4;
  localparam int unsigned MulSteps = 4;
  localparam int unsigned DivSteps = 16;

  localparam logic [29:0] NsPerS   = 30'd1000000000;
  localparam logic [29:0] RoundUp  = 30'd999999999;
  localparam logic [31:0] NsPerS1x = 32'd1000000000;
  localparam logic [31:0] NsPerS2x = 32'd2000000000;
  localparam logic [31:0] NsPerS3x = 32'd3000000000;
  localparam logic [4:0]  Overhead = 5'd24;

  localparam logic [RateW-1:0]  UpRateRst    = 37'd500000;
  localparam logic [BurstW-1:0] UpBurstRst   = 32'd65536;
  localparam logic [RateW-1:0]  DownRateRst  = 37'd1250000;
  localparam logic [BurstW-1:0] DownBurstRst = 32'd163840;

  typedef enum logic [CfgIdxW-1:0] {
    CfgUpRate    = 2'd0,
    CfgUpBurst   = 2'd1,
    CfgDownRate  = 2'd2,
    CfgDownBurst = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic slot_ld;
    logic mem_rd;
    logic delta_ld;
    logic mul_step;
    logic cmp_ld;
    logic div_step;
    logic write_back;
    logic emit_zero;
  } cmd_t;

  typedef struct packed {
    logic rate_zero;
    logic clear_last;
    logic mul_last;
    logic div_last;
    logic refill_sat;
  } status_t;

endpackage

@@ src/pftbp_ctrl.sv @@
// Sequencing state machine of the policer.
module pftbp_ctrl import pftbp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output logic    busy,
  output cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    StClear = 9'b000000001,
    StIdle  = 9'b000000010,
    StSlot  = 9'b000000100,
    StRead  = 9'b000001000,
    StDelta = 9'b000010000,
    StMul   = 9'b000100000,
    StCmp   = 9'b001000000,
    StDiv   = 9'b010000000,
    StWrite = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = StSlot;
        end
      end
      StSlot: begin
        // zero rate: pass without touching the bucket
        if (status_i.rate_zero) begin
          cmd_o.emit_zero = 1'b1;
          state_d         = StIdle;
        end else begin
          cmd_o.slot_ld = 1'b1;
          state_d       = StRead;
        end
      end
      StRead: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = StDelta;
      end
      StDelta: begin
        cmd_o.delta_ld = 1'b1;
        state_d        = StMul;
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        cmd_o.cmp_ld = 1'b1;
        state_d      = status_i.refill_sat ? StWrite : StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        cmd_o.write_back = 1'b1;
        state_d          = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/pftbp_datapath.sv @@
// Datapath of the policer: config registers, bucket memory, refill arithmetic.
module pftbp_datapath import pftbp_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RateW-1:0]   cfg_wdata_i,
  input  logic [IdxW-1:0]    bucket_index_i,
  input  logic               direction_i,
  input  logic [LenW-1:0]    packet_length_i,
  input  logic [TimeW-1:0]   now_ns_i,
  input  logic               rates_found_i,
  input  logic [RateW-1:0]   flow_rate_i,
  input  logic [BurstW-1:0]  flow_burst_i,
  output logic               pass_o,
  output logic               pass_valid_o
);

  localparam int unsigned SlotW  = $clog2(NUM_BUCKETS);
  localparam int unsigned AddrW  = SlotW + 1;
  localparam int unsigned Depth  = 2 * NUM_BUCKETS;
  localparam int unsigned EntryW = 1 + BurstW + TimeW;
  // slot = index mod NUM_BUCKETS by reciprocal; exact for 12 bit indexes
  localparam logic [23:0] RecipC = 24'((2**24 + NUM_BUCKETS - 1) / NUM_BUCKETS);
  localparam logic [30:0] NumC   = 31'(NUM_BUCKETS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  // config
  logic [RateW-1:0]  up_rate_q, down_rate_q;
  logic [BurstW-1:0] up_burst_q, down_burst_q;

  // item context
  logic [IdxW-1:0]   idx_q, qest_q;
  logic              dir_q;
  logic [LenW-1:0]   len_q;
  logic [TimeW-1:0]  now_q;
  logic [RateW-1:0]  rate_q;
  logic [BurstW-1:0] burst_q;
  logic [AddrW-1:0]  addr_q;

  // memory
  logic [EntryW-1:0] mem_q [Depth];
  logic [EntryW-1:0] rd_q;
  logic [AddrW-1:0]  clr_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [EntryW-1:0] mem_wdata;

  // arithmetic
  logic [BurstW-1:0] tok_q, h_q, quot_q;
  logic [DeltaW-1:0] dlt_q;
  logic [ProdW-1:0]  acc_q;
  logic [LimW-1:0]   lim_q;
  logic [StepW-1:0]  step_q;
  logic              sat_q;
  logic [31:0]       nlo_q;
  logic [RemW-1:0]   pr_q;
  logic              pass_q, strobe_q;

  logic [35:0]       qest_w;
  logic [30:0]       slot_w;
  logic              rd_vld;
  logic [BurstW-1:0] rd_tok, tok_base;
  logic [TimeW-1:0]  rd_last, delta_w;
  logic [30:0]       pp_a;
  logic [18:0]       pp_b;
  logic [49:0]       pp;
  logic [ProdW-1:0]  addend;
  logic [BurstW-1:0] hm1;
  logic [LimW-1:0]   numer;
  logic [31:0]       trial;
  logic [1:0]        digit;
  logic [31:0]       dsub;
  logic [BurstW-1:0] tnew, tstore;
  logic [16:0]       need;
  logic              pass_w;

  // ---------------- config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_rate_q    <= UpRateRst;
      up_burst_q   <= UpBurstRst;
      down_rate_q  <= DownRateRst;
      down_burst_q <= DownBurstRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgUpRate:    up_rate_q    <= cfg_wdata_i;
        CfgUpBurst:   up_burst_q   <= cfg_wdata_i[BurstW-1:0];
        CfgDownRate:  down_rate_q  <= cfg_wdata_i;
        CfgDownBurst: down_burst_q <= cfg_wdata_i[BurstW-1:0];
      endcase
    end
  end

  // ---------------- item capture and slot index
  assign qest_w = {24'b0, bucket_index_i} * {12'b0, RecipC};
  assign slot_w = {19'b0, idx_q} - ({19'b0, qest_q} * NumC);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q  <= bucket_index_i;
      qest_q <= qest_w[35:24];
      dir_q  <= direction_i;
      len_q  <= packet_length_i;
      now_q  <= now_ns_i;
      if (rates_found_i) begin
        rate_q  <= flow_rate_i;
        burst_q <= flow_burst_i;
      end else if (direction_i) begin
        rate_q  <= down_rate_q;
        burst_q <= down_burst_q;
      end else begin
        rate_q  <= up_rate_q;
        burst_q <= up_burst_q;
      end
    end
    if (cmd_i.slot_ld) begin
      addr_q <= {slot_w[SlotW-1:0], dir_q};
    end
  end

  // ---------------- bucket memory {valid, tokens, last time}
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  assign mem_we    = cmd_i.clear_wr | cmd_i.write_back;
  assign mem_waddr = cmd_i.clear_wr ? clr_q : addr_q;
  assign mem_wdata = cmd_i.clear_wr ? '0 : {1'b1, tstore, now_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[addr_q];
    end
  end

  assign rd_vld  = rd_q[EntryW-1];
  assign rd_tok  = rd_q[TimeW +: BurstW];
  assign rd_last = rd_q[TimeW-1:0];

  // ---------------- elapsed time and headroom
  assign tok_base = rd_vld ? rd_tok : burst_q;
  assign delta_w  = rd_vld ? (now_q - rd_last) : '0;

  // ---------------- elapsed * rate, four 31x19 partial products
  assign pp_a = step_q[0] ? dlt_q[61:31] : dlt_q[30:0];
  assign pp_b = step_q[1] ? {1'b0, rate_q[36:19]} : rate_q[18:0];
  assign pp   = {19'b0, pp_a} * {31'b0, pp_b};

  always_comb begin
    case (step_q[1:0])
      2'd0:    addend = {49'b0, pp};
      2'd1:    addend = {18'b0, pp, 31'b0};
      2'd2:    addend = {30'b0, pp, 19'b0};
      default: addend = {pp[48:0], 50'b0};
    endcase
  end

  // refill reaches headroom h when product > (h-1) * 1e9
  assign hm1   = h_q - 32'd1;
  assign numer = acc_q[LimW-1:0] + {32'b0, RoundUp};

  // ---------------- radix-4 division by 1e9
  assign trial = {pr_q, nlo_q[31:30]};
  always_comb begin
    if (trial >= NsPerS3x) begin
      digit = 2'd3;
      dsub  = NsPerS3x;
    end else if (trial >= NsPerS2x) begin
      digit = 2'd2;
      dsub  = NsPerS2x;
    end else if (trial >= NsPerS1x) begin
      digit = 2'd1;
      dsub  = NsPerS1x;
    end else begin
      digit = 2'd0;
      dsub  = '0;
    end
  end

  // ---------------- token update
  assign tnew   = sat_q ? burst_q : (tok_q + quot_q);
  assign need   = {1'b0, len_q} + {12'b0, Overhead};
  assign pass_w = (tnew >= {15'b0, need});
  assign tstore = pass_w ? (tnew - {15'b0, need}) : tnew;

  always_ff @(posedge clk_i) begin
    if (cmd_i.delta_ld) begin
      tok_q <= tok_base;
      h_q   <= (tok_base >= burst_q) ? '0 : (burst_q - tok_base);
      dlt_q <= (|delta_w[63:62]) ? '1 : delta_w[DeltaW-1:0];
      acc_q <= '0;
    end
    if (cmd_i.mul_step) begin
      acc_q <= acc_q + addend;
      lim_q <= {30'b0, hm1} * {32'b0, NsPerS};
    end
    if (cmd_i.cmp_ld) begin
      sat_q  <= status_o.refill_sat;
      pr_q   <= numer[61:32];
      nlo_q  <= numer[31:0];
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      pr_q   <= RemW'(trial - dsub);
      nlo_q  <= {nlo_q[29:0], 2'b0};
      quot_q <= {quot_q[29:0], digit};
    end
    if (cmd_i.write_back) begin
      pass_q <= pass_w;
    end else if (cmd_i.emit_zero) begin
      pass_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.write_back | cmd_i.emit_zero;
      if (cmd_i.delta_ld || cmd_i.cmp_ld) begin
        step_q <= '0;
      end else if (cmd_i.mul_step || cmd_i.div_step) begin
        step_q <= step_q + StepW'(1);
      end
    end
  end

  // ---------------- status
  assign status_o.rate_zero  = (rate_q == '0);
  assign status_o.clear_last = (clr_q == LastAddr);
  assign status_o.mul_last   = (step_q == StepW'(MulSteps - 1));
  assign status_o.div_last   = (step_q == StepW'(DivSteps - 1));
  assign status_o.refill_sat = (h_q == '0) || (acc_q > {37'b0, lim_q});

  assign pass_o       = pass_q;
  assign pass_valid_o = strobe_q;

endmodule

@@ src/per_flow_token_bucket_policer_unit.sv @@
// Top level of the per-flow token bucket policer.
//
// Usage: present a packet's fields and raise start; the item is taken at a
// rising edge where start is high and busy is low. busy stays high until
// the item's verdict has been produced. pass_o carries the verdict (1
// forward, 0 drop), flagged by pass_valid_o for exactly one cycle; the
// receiver cannot stall, so it must sample on that cycle.
// Items are taken one at a time. The full path runs the partial-product
// multiply of elapsed time by rate and then the radix-4 divide by 1e9.
// When the refill fills the bucket (or the bucket is first seen) the
// divide is skipped. A zero rate passes the packet without a memory
// access.
// Reset: config registers load their defaults and a clearing pass writes
// every bucket entry invalid, with busy held high.
// Config writes (cfg_we_i/cfg_idx_i/cfg_wdata_i) take effect at once and
// should only be issued while no item is in flight.
module per_flow_token_bucket_policer_unit import pftbp_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               start,
  output logic               busy,
  input  logic [IdxW-1:0]    bucket_index_i,
  input  logic               direction_i,
  input  logic [LenW-1:0]    packet_length_i,
  input  logic [TimeW-1:0]   now_ns_i,
  input  logic               rates_found_i,
  input  logic [RateW-1:0]   flow_rate_i,
  input  logic [BurstW-1:0]  flow_burst_i,
  // verdict
  output logic               pass_o,
  output logic               pass_valid_o,
  // config write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RateW-1:0]   cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  // sequencer: clear sweep, then one item at a time
  pftbp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // bucket state, refill math and verdict register
  pftbp_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .bucket_index_i  (bucket_index_i),
    .direction_i     (direction_i),
    .packet_length_i (packet_length_i),
    .now_ns_i        (now_ns_i),
    .rates_found_i   (rates_found_i),
    .flow_rate_i     (flow_rate_i),
    .flow_burst_i    (flow_burst_i),
    .pass_o          (pass_o),
    .pass_valid_o    (pass_valid_o)
  );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the per-flow token bucket policer: directed cases, then random traffic.
module tb;
  import pftbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBuckets = 4096;
  // Longest quiet stretch: reset clearing pass plus slack.
  localparam int unsigned StallLimit = 20000;
  localparam logic [127:0] NsPerSec  = 128'd1000000000;
  localparam logic [127:0] RoundUpNs = 128'd999999999;
  localparam logic [127:0] RefillCap = 128'd1 << 34;
  localparam logic [63:0]  PktOverhead = 64'd24;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // DUT inputs, all known from time zero
  logic              start           = 1'b0;
  logic [IdxW-1:0]   bucket_index_i  = '0;
  logic              direction_i     = 1'b0;
  logic [LenW-1:0]   packet_length_i = '0;
  logic [TimeW-1:0]  now_ns_i        = '0;
  logic              rates_found_i   = 1'b0;
  logic [RateW-1:0]  flow_rate_i     = '0;
  logic [BurstW-1:0] flow_burst_i    = '0;
  logic              cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i      = '0;
  logic [RateW-1:0]  cfg_wdata_i     = '0;

  logic busy;
  logic pass_o;
  logic pass_valid_o;

  per_flow_token_bucket_policer_unit #(
    .NUM_BUCKETS(NumBuckets)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .bucket_index_i (bucket_index_i),
    .direction_i    (direction_i),
    .packet_length_i(packet_length_i),
    .now_ns_i       (now_ns_i),
    .rates_found_i  (rates_found_i),
    .flow_rate_i    (flow_rate_i),
    .flow_burst_i   (flow_burst_i),
    .pass_o         (pass_o),
    .pass_valid_o   (pass_valid_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Bucket model: default registers per direction and one bucket per
  // (slot, direction) entry, entry = slot*2 + direction.
  // ---------------------------------------------------------------------------
  logic [RateW-1:0]  dflt_rate  [2] = '{UpRateRst, DownRateRst};
  logic [BurstW-1:0] dflt_burst [2] = '{UpBurstRst, DownBurstRst};

  bit                bkt_valid  [2*NumBuckets];
  logic [BurstW-1:0] bkt_tokens [2*NumBuckets];
  logic [TimeW-1:0]  bkt_last   [2*NumBuckets];

  bit verdict_q [$];       // verdicts of accepted packets, oldest first

  int unsigned idle_pct  = 0;   // sender idle chance per packet, percent
  int unsigned sent_cnt  = 0;
  int unsigned fwd_cnt   = 0;
  int unsigned drop_cnt  = 0;
  int unsigned fail_cnt  = 0;
  logic [TimeW-1:0] clock_ns = '0;

  // Police one packet against the bucket model; updates the bucket state.
  function automatic bit police_packet(logic [IdxW-1:0] idx, bit dir, logic [LenW-1:0] len,
                                       logic [TimeW-1:0] now, bit found,
                                       logic [RateW-1:0] frate, logic [BurstW-1:0] fburst);
    logic [RateW-1:0]  rate;
    logic [BurstW-1:0] burst;
    int unsigned       ent;
    logic [63:0]       tok;
    logic [63:0]       last;
    logic [63:0]       elapsed;
    logic [127:0]      fill;
    bit                fwd;
    rate  = found ? frate  : dflt_rate[dir];
    burst = found ? fburst : dflt_burst[dir];
    // zero rate: forward, bucket untouched
    if (rate == '0) return 1'b1;
    ent = (int'(idx) % NumBuckets) * 2 + int'(dir);
    if (bkt_valid[ent]) begin
      tok  = 64'(bkt_tokens[ent]);
      last = bkt_last[ent];
    end else begin
      tok  = 64'(burst);   // first packet finds the bucket full
      last = now;
    end
    elapsed = now - last;  // wraps when time runs backwards
    fill = (128'(elapsed) * 128'(rate) + RoundUpNs) / NsPerSec;
    if (fill > RefillCap) fill = RefillCap;
    tok = tok + fill[63:0];
    if (tok > 64'(burst)) tok = 64'(burst);
    fwd = (tok >= 64'(len) + PktOverhead);
    if (fwd) tok = tok - (64'(len) + PktOverhead);
    bkt_valid[ent]  = 1'b1;
    bkt_tokens[ent] = tok[BurstW-1:0];
    bkt_last[ent]   = now;
    return fwd;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Present one packet, wait until it is taken, queue its verdict.
  // Called at a rising edge; start is only lowered when a gap is inserted.
  task automatic send_packet(logic [IdxW-1:0] idx, bit dir, logic [LenW-1:0] len,
                             logic [TimeW-1:0] now, bit found,
                             logic [RateW-1:0] frate, logic [BurstW-1:0] fburst);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 40);
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    bucket_index_i  <= idx;
    direction_i     <= dir;
    packet_length_i <= len;
    now_ns_i        <= now;
    rates_found_i   <= found;
    flow_rate_i     <= frate;
    flow_burst_i    <= fburst;
    do @(posedge clk_i); while (busy !== 1'b0);
    verdict_q.push_back(police_packet(idx, dir, len, now, found, frate, fburst));
    sent_cnt++;
  endtask

  // Stop sending, let every verdict come back and the block settle.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  // Write one default register; the model follows at the write edge.
  task automatic set_default(cfg_idx_e which, logic [RateW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= which;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (which)
      CfgUpRate:    dflt_rate[0]  = val;
      CfgUpBurst:   dflt_burst[0] = val[BurstW-1:0];
      CfgDownRate:  dflt_rate[1]  = val;
      CfgDownBurst: dflt_burst[1] = val[BurstW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Checking: every strobe is matched against the oldest queued verdict.
  // Sampled right after the edge, so values are those of the ending cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && pass_valid_o === 1'b1) begin
      if (verdict_q.size() == 0) begin
        $error("pass_valid_o with no packet outstanding, pass actual %0b", pass_o);
        fail_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (pass_o !== want) begin
          $error("pass: expected %0b, actual %0b", want, pass_o);
          fail_cnt++;
        end
        if (want) fwd_cnt++;
        else drop_cnt++;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((start === 1'b1 && busy === 1'b0) || pass_valid_o === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("per_flow_token_bucket_policer_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers still at their reset values.
  task automatic test_reset_defaults();
    idle_pct = 0;
    send_packet(12'd0,   1'b0, 16'd0,    64'd0,    1'b0, '0, '0);  // new bucket at time zero
    send_packet(12'd0,   1'b0, 16'hFFFF, 64'd1000, 1'b0, '0, '0);  // longer than upstream burst
    send_packet(12'hFFF, 1'b1, 16'hFFFF, 64'd0,    1'b0, '0, '0);  // fits downstream burst
    send_packet(12'd0,   1'b0, 16'd1000, 64'd0,    1'b0, '0, '0);  // clock ran backwards
    wait_idle();
  endtask

  // Defaults at their extremes: zero rate, full-scale rate, zero and full burst.
  task automatic test_config_extremes();
    set_default(CfgUpRate,    '0);
    set_default(CfgUpBurst,   '1);
    set_default(CfgDownRate,  '1);
    set_default(CfgDownBurst, '0);
    send_packet(12'd1, 1'b0, 16'd100,  64'd5000, 1'b0, '0,       '0);    // zero default rate
    send_packet(12'd1, 1'b0, 16'd50,   64'd6000, 1'b1, 37'd1000, 32'd100);
    send_packet(12'd1, 1'b0, 16'd0,    64'd7000, 1'b0, '0,       '0);    // no state change
    send_packet(12'd1, 1'b0, 16'd0,    64'd7001, 1'b1, 37'd1000, 32'd100);
    send_packet(12'd2, 1'b1, 16'd0,    64'd8000, 1'b0, '0,       '0);    // zero burst: drop
    send_packet(12'd2, 1'b1, 16'hFFFF, '1,       1'b1, '1,       '1);
    send_packet(12'd2, 1'b1, 16'hFFFF, 64'd0,    1'b1, '1,       '1);    // time wraps
    wait_idle();
  endtask

  // Per-flow corner cases: lowered burst, per-flow zero rate, stored time on drop.
  task automatic test_flow_edges();
    send_packet(12'd3, 1'b0, 16'd0,  64'd9000, 1'b1, 37'd1000000, 32'd1000000);
    send_packet(12'd3, 1'b0, 16'd20, 64'd9100, 1'b1, 37'd1000000, 32'd50);  // burst cut
    send_packet(12'd3, 1'b0, 16'd20, 64'd9200, 1'b1, '0,          32'd50);  // zero rate
    send_packet(12'd3, 1'b0, 16'd40, 64'd9300, 1'b1, 37'd1000000, 32'd50);  // drop
    send_packet(12'd3, 1'b0, 16'd10, 64'd9400, 1'b1, 37'd1000000, 32'd50);
    send_packet(12'd4, 1'b1, 16'd0,  64'h8000_0000_0000_0000, 1'b1, 37'h10_0000_0000,
                32'h8000_0000);
    send_packet(12'd4, 1'b1, 16'd7,  64'h8000_0000_0000_0001, 1'b1, 37'd1, 32'h8000_0000);
    wait_idle();
  endtask

  // Random traffic: mostly a few steady flows, some noise and broken cases.
  task automatic run_traffic(int unsigned count, int unsigned pct);
    logic [IdxW-1:0]   hot_slot  [16];
    logic [RateW-1:0]  hot_rate  [16];
    logic [BurstW-1:0] hot_burst [16];
    bit                hot_found [16];
    bit                hot_dir   [16];
    int unsigned       k;
    int unsigned       pick;
    idle_pct = pct;
    for (k = 0; k < 16; k++) begin
      hot_slot[k]  = (k < 12) ? IdxW'($urandom_range(0, 15)) : IdxW'($urandom);
      hot_rate[k]  = RateW'($urandom_range(100000, 20000000));
      hot_burst[k] = $urandom_range(200, 10000);
      hot_found[k] = $urandom_range(1);
      hot_dir[k]   = $urandom_range(1);
    end
    repeat (count) begin
      pick = $urandom_range(99);
      k = $urandom_range(15);
      if (pick < 70) begin
        // steady flow, monotonic time
        clock_ns = clock_ns + 64'($urandom_range(0, 100000));
        send_packet(hot_slot[k], hot_dir[k], LenW'($urandom_range(0, 1500)), clock_ns,
                    hot_found[k], hot_rate[k], hot_burst[k]);
      end else if (pick < 85) begin
        // noise over the full range of every field
        if ($urandom_range(9) == 0) clock_ns = {$urandom, $urandom};
        else clock_ns = clock_ns + 64'($urandom);
        send_packet(IdxW'($urandom), 1'($urandom), LenW'($urandom), clock_ns,
                    1'($urandom), RateW'({$urandom, $urandom}), $urandom);
      end else begin
        case ($urandom_range(2))
          0: send_packet(hot_slot[k], hot_dir[k], LenW'($urandom_range(0, 1500)),
                         clock_ns - 64'($urandom_range(1, 1000000)),    // stale time
                         hot_found[k], hot_rate[k], hot_burst[k]);
          1: send_packet(hot_slot[k], hot_dir[k], LenW'($urandom), clock_ns,
                         1'b1, '0, hot_burst[k]);                      // zero rate
          default: send_packet(hot_slot[k], hot_dir[k], LenW'($urandom_range(0, 100)),
                               clock_ns, 1'b1, hot_rate[k],
                               BurstW'($urandom_range(0, hot_burst[k] / 4)));  // lowered
        endcase
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_config_extremes();
    test_flow_edges();

    // sender idles often-ish, moderate defaults
    clock_ns = 64'd20000;
    set_default(CfgUpRate,    37'd3000000);
    set_default(CfgUpBurst,   37'd6000);
    set_default(CfgDownRate,  37'd800000);
    set_default(CfgDownBurst, 37'd3000);
    run_traffic(420, 15);

    // sender idles most of the time, extreme defaults
    set_default(CfgUpRate,    '1);
    set_default(CfgUpBurst,   '0);
    set_default(CfgDownRate,  37'd1);
    set_default(CfgDownBurst, 37'hFFFF_FFFF);
    run_traffic(420, 81);

    // back to back, random defaults; burst writes carry junk above bit 31
    set_default(CfgUpRate,    RateW'($urandom_range(1, 30000000)));
    set_default(CfgUpBurst,   {5'($urandom), 32'($urandom_range(100, 20000))});
    set_default(CfgDownRate,  RateW'($urandom_range(1, 30000000)));
    set_default(CfgDownBurst, {5'($urandom), 32'($urandom_range(100, 20000))});
    run_traffic(420, 0);

    $display("policed %0d packets (%0d forwarded, %0d dropped) over 5 default settings",
             sent_cnt, fwd_cnt, drop_cnt);
    $display("sender idle mixes: none, 15%%, 81%%; %0d mismatches", fail_cnt);
    if (fail_cnt == 0) begin
      $display("per_flow_token_bucket_policer_unit: match");
    end else begin
      $display("per_flow_token_bucket_policer_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/pftbp_pkg.sv
src/pftbp_ctrl.sv
src/pftbp_datapath.sv
src/per_flow_token_bucket_policer_unit.sv
sim/tb.sv
